// ===== rtl/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// Perspective point projection package
// Shared widths, mode codes and transfer payload types for the projector.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int NUM_CAMERAS_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int ROWS      = 3;
    localparam int ROW_COEFS = 4;
    localparam int COEFS     = ROWS * ROW_COEFS;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = SUM_W - 1;
    localparam int Q_W       = 32;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_PROJECT = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [7:0]         camera;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] point_w;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] image_u;
        logic signed [31:0] image_v;
        logic               zero_depth;
        logic               overflow;
    } res_t;

    // Unsigned quotient with its sign and a quotient-too-large flag.
    typedef struct packed {
        logic [Q_W-1:0] quo;
        logic           big;
        logic           neg;
    } div_res_t;

endpackage

// ===== rtl/ppp_dot_lane.sv =====
// ----------------------------------------------------------------------------
// Row dot product lane
// Multiplies one matrix row with the point and sums the four exact products.
// ----------------------------------------------------------------------------
module ppp_dot_lane (
    input  logic                                          clk,
    input  logic                                          en,
    input  logic                                          keep,
    input  logic [ppp_pkg::ROW_COEFS-1:0][ppp_pkg::COEF_W-1:0] coef,
    input  logic [ppp_pkg::ROW_COEFS-1:0][ppp_pkg::COEF_W-1:0] point,
    output logic signed [ppp_pkg::SUM_W-1:0]              sum
);
    import ppp_pkg::*;

    logic signed [PROD_W-1:0] prod_reg  [ROW_COEFS];
    logic signed [PROD_W-1:0] prod_next [ROW_COEFS];
    logic signed [SUM_W-1:0]  sum_reg;

    // Products; a camera outside the table reads as an all-zero row.
    always_comb
    begin
        for (int k = 0; k < ROW_COEFS; k++)
        begin
            logic signed [COEF_W-1:0] c_s;
            logic signed [COEF_W-1:0] p_s;
            c_s = keep ? signed'(coef[k]) : '0;
            p_s = signed'(point[k]);
            prod_next[k] = c_s * p_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROW_COEFS; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            sum_reg <= SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                     + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);
        end
    end

    assign sum = sum_reg;

endmodule

// ===== rtl/ppp_div_lane.sv =====
// ----------------------------------------------------------------------------
// Pipelined quotient lane
// Restoring division of num * 2^FRAC_BITS by den, one quotient bit a stage.
// ----------------------------------------------------------------------------
module ppp_div_lane #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ppp_pkg::MAG_W-1:0]   num_mag,
    input  logic [ppp_pkg::MAG_W-1:0]   den_mag,
    input  logic                        neg,
    output ppp_pkg::div_res_t           res
);
    import ppp_pkg::*;

    localparam int RW = MAG_W + FRAC_BITS + Q_W;

    logic [RW-1:0]    rem_reg [Q_W+1];
    logic [MAG_W-1:0] den_reg [Q_W+1];
    logic [Q_W-1:0]   quo_reg [Q_W+1];
    logic             neg_reg [Q_W+1];
    logic             big_reg [Q_W+1];

    logic [RW-1:0] num_ext;
    logic [RW-1:0] den_top;

    assign num_ext = RW'(num_mag) << FRAC_BITS;
    assign den_top = RW'(den_mag) << Q_W;

    // Entry stage: flag quotients that cannot fit in Q_W bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_ext;
            den_reg[0] <= den_mag;
            quo_reg[0] <= '0;
            neg_reg[0] <= neg;
            big_reg[0] <= (num_ext >= den_top);
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        localparam int SH = Q_W - 1 - s;
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = RW'(den_reg[s]) << SH;
        assign ge    = (rem_reg[s] >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? (rem_reg[s] - trial) : rem_reg[s];
                quo_reg[s+1] <= quo_reg[s] | (ge ? (Q_W'(1) << SH) : '0);
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                big_reg[s+1] <= big_reg[s];
            end
        end
    end

    assign res = '{quo: quo_reg[Q_W], big: big_reg[Q_W], neg: neg_reg[Q_W]};

endmodule

// ===== rtl/perspective_point_projection_core.sv =====
// ----------------------------------------------------------------------------
// Perspective point projection core
// Per-camera 3x4 matrix table, three row lanes, two quotient lanes, merge.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits under stall.
// Reset clears all valid bits; the matrix table is not cleared and holds
// unknown data until each coefficient is loaded.
// ----------------------------------------------------------------------------
module perspective_point_projection_core #(
    parameter int NUM_CAMERAS = ppp_pkg::NUM_CAMERAS_DEF,
    parameter int FRAC_BITS   = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  ppp_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output ppp_pkg::res_t res
);
    import ppp_pkg::*;

    localparam int AW      = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
    localparam int DIV_LAT = Q_W + 1;
    localparam int LAT     = 4 + DIV_LAT + 1;

    logic en;
    logic cmd_acc;
    logic load_acc;
    logic proj_acc;
    logic cam_ok;
    logic [AW-1:0] cam_addr;
    logic [COEFS-1:0] wr_en;

    logic [COEFS-1:0][COEF_W-1:0]     coef_reg;
    logic [ROW_COEFS-1:0][COEF_W-1:0] pt_reg;
    logic                             cam_ok_reg;

    logic signed [SUM_W-1:0] row_sum [ROWS];
    logic [MAG_W-1:0]        mag_reg [ROWS];
    logic                    neg_reg [ROWS];
    logic                    zero_reg;
    logic                    zero_dly_reg [DIV_LAT];

    div_res_t div_u;
    div_res_t div_v;

    logic [LAT-1:0] vld_reg;
    res_t           res_reg;
    res_t           res_next;

    // Transfer control: the pipeline moves unless a result is held.
    assign en       = !(vld_reg[LAT-1] && res_stall);
    assign cmd_stall = !en;
    assign cmd_acc  = cmd_valid && en;
    assign load_acc = cmd_acc && (cmd.mode == MODE_LOAD);
    assign proj_acc = cmd_acc && (cmd.mode == MODE_PROJECT);
    assign cam_ok   = (32'(cmd.camera) < NUM_CAMERAS);
    assign cam_addr = AW'(cmd.camera);

    // Write enables, one bank per coefficient position.
    always_comb
    begin
        for (int k = 0; k < COEFS; k++)
        begin
            wr_en[k] = load_acc && cam_ok && (cmd.coef_index == 4'(k));
        end
    end

    // Coefficient banks, each indexed by camera, read registered.
    for (genvar k = 0; k < COEFS; k++)
    begin : g_bank
        logic [COEF_W-1:0] mem [NUM_CAMERAS];

        always_ff @(posedge clk)
        begin
            if (wr_en[k])
            begin
                mem[cam_addr] <= cmd.coef_value;
            end
            if (en)
            begin
                coef_reg[k] <= mem[cam_addr];
            end
        end
    end

    // Point capture alongside the table read.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg     <= {cmd.point_w, cmd.point_z, cmd.point_y, cmd.point_x};
            cam_ok_reg <= cam_ok;
        end
    end

    // One dot product lane per matrix row.
    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        ppp_dot_lane u_dot (
            .clk   (clk),
            .en    (en),
            .keep  (cam_ok_reg),
            .coef  (coef_reg[ROW_COEFS*r+ROW_COEFS-1 : ROW_COEFS*r]),
            .point (pt_reg),
            .sum   (row_sum[r])
        );
    end

    // Sign and magnitude of each row result, plus the zero depth test.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                neg_reg[r] <= row_sum[r][SUM_W-1];
                mag_reg[r] <= MAG_W'(row_sum[r][SUM_W-1] ? -row_sum[r] : row_sum[r]);
            end
            zero_reg <= (row_sum[2] == '0);
            zero_dly_reg[0] <= zero_reg;
            for (int d = 1; d < DIV_LAT; d++)
            begin
                zero_dly_reg[d] <= zero_dly_reg[d-1];
            end
        end
    end

    // Quotient lanes for u and v share the depth as divisor.
    ppp_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_u (
        .clk     (clk),
        .en      (en),
        .num_mag (mag_reg[0]),
        .den_mag (mag_reg[2]),
        .neg     (neg_reg[0] ^ neg_reg[2]),
        .res     (div_u)
    );

    ppp_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_v (
        .clk     (clk),
        .en      (en),
        .num_mag (mag_reg[1]),
        .den_mag (mag_reg[2]),
        .neg     (neg_reg[1] ^ neg_reg[2]),
        .res     (div_v)
    );

    // Saturate one quotient; the top bit of the result is the overflow flag.
    function automatic logic [Q_W:0] sat_quo(input div_res_t d);
        logic           over;
        logic [Q_W-1:0] val;
        over = d.big || (d.neg ? (d.quo > {1'b1, {(Q_W-1){1'b0}}})
                               : (d.quo > {1'b0, {(Q_W-1){1'b1}}}));
        if (over)
        begin
            val = d.neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end
        else
        begin
            val = d.neg ? (Q_W'(0) - d.quo) : d.quo;
        end
        return {over, val};
    endfunction

    // Merge the lanes into one result.
    always_comb
    begin
        logic [Q_W:0] su;
        logic [Q_W:0] sv;
        su = sat_quo(div_u);
        sv = sat_quo(div_v);
        if (zero_dly_reg[DIV_LAT-1])
        begin
            res_next = '{image_u: '0, image_v: '0, zero_depth: 1'b1, overflow: 1'b0};
        end
        else
        begin
            res_next = '{image_u: signed'(su[Q_W-1:0]), image_v: signed'(sv[Q_W-1:0]),
                         zero_depth: 1'b0, overflow: su[Q_W] | sv[Q_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    // Valid bits track project items through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], proj_acc};
        end
    end

    assign res_valid = vld_reg[LAT-1];
    assign res       = res_reg;

    // A zero depth result carries zero coordinates and no overflow.
    a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.zero_depth) |->
            (res.image_u == '0 && res.image_v == '0 && !res.overflow))
        else $error("zero depth result with nonzero fields");

    // A load transfer never enters the result pipeline.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && cmd.mode == MODE_LOAD) |=> !vld_reg[0])
        else $error("load transfer produced a pipeline item");

endmodule
